// ===== hw/rtl/teq_pkg.sv =====
// Shared constants, types and the ring-slot helper of the timed event queue.
package teq_pkg;

   localparam int DEPTH    = 16;
   localparam int TAG_BITS = 16;

   localparam int TIME_W      = 32;
   localparam int TAG_FIELD_W = 16;
   localparam int COUNT_W     = 5;
   localparam int TAG_W       = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
   localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W       = $clog2(DEPTH + 1);

   localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(DEPTH);
   localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 56;

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_EXEC = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ACK  = 2'd0,
      KIND_FIRE = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_INS  = 5'b00010,
      ST_PUT  = 5'b00100,
      ST_EXE  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] due;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   // Physical slot of a logical position counted from the head of the ring.
   function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] offset);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/timed_event_queue_unit.sv =====
// Timed event queue: a time-sorted ring of pending events held in one RAM.
// An add into an empty queue is written at once and an add into a full queue is rejected;
// otherwise it walks from the tail, moving each stored event with an equal or later due time
// one slot back, then writes it. An execute fires due events from the head, then finishes.
// One request at a time: the next is taken the cycle after the final result is loaded, and
// output stalls can hold it back. Synchronous reset empties the queue; RAM is not cleared.
module timed_event_queue_unit (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // [31:0] due_time, [63:32] current_time, [79:64] event_tag
   input  logic [0:0]  req_tuser,  // [0] command
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // [15:0] fired_tag, [47:16] fired_time,
                                   // [52:48] fired_count, [53] rejected, [55:54] zero
   output logic [1:0]  rsp_tuser,  // [1:0] kind
   output logic        rsp_tlast   // last result of the request
);

   // Request fields.
   logic                            req_fire;
   logic                            req_is_exec;
   logic [teq_pkg::TIME_W-1:0]      req_due_time;
   logic [teq_pkg::TIME_W-1:0]      req_current_time;
   logic [teq_pkg::TAG_FIELD_W-1:0] req_event_tag;

   assign req_due_time     = req_tdata[31:0];
   assign req_current_time = req_tdata[63:32];
   assign req_event_tag    = req_tdata[79:64];
   assign req_is_exec      = (req_tuser[0] == teq_pkg::CMD_EXEC);

   // Control state.
   teq_pkg::state_type              state_ff, state_in;
   logic [teq_pkg::IDX_W-1:0]       head_ff, head_in;
   logic [teq_pkg::OCC_W-1:0]       occ_ff, occ_in;
   logic [teq_pkg::IDX_W-1:0]       ins_idx_ff, ins_idx_in;
   logic [teq_pkg::COUNT_W-1:0]     fired_ff, fired_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // Request payload kept for the duration of the request.
   logic [teq_pkg::TIME_W-1:0]      new_due_ff, new_due_in;
   logic [teq_pkg::TAG_W-1:0]       new_tag_ff, new_tag_in;
   logic [teq_pkg::TIME_W-1:0]      now_ff, now_in;
   logic                            is_exec_ff, is_exec_in;
   logic                            rejected_ff, rejected_in;

   // Output register payload.
   teq_pkg::kind_type               rsp_kind_ff, rsp_kind_in;
   logic [teq_pkg::TAG_FIELD_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic [teq_pkg::TIME_W-1:0]      rsp_time_ff, rsp_time_in;
   logic [teq_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                            rsp_rej_ff, rsp_rej_in;
   logic                            rsp_last_ff, rsp_last_in;

   // RAM port.
   logic                            wr_en;
   logic [teq_pkg::IDX_W-1:0]       wr_addr;
   teq_pkg::entry_type              wr_data;
   logic [teq_pkg::IDX_W-1:0]       rd_addr;
   teq_pkg::entry_type              rd_data;

   logic                            out_free;
   logic                            load_rsp;
   logic                            rd_is_late;
   logic                            rd_is_due;
   teq_pkg::entry_type              new_entry;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == teq_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign new_entry.due = new_due_ff;
   assign new_entry.tag = new_tag_ff;

   // Stored entry must move back when its time is not below the new one, so that the new
   // event lands ahead of every event with the same time.
   assign rd_is_late = !($signed(rd_data.due) < $signed(new_due_ff));
   assign rd_is_due  = $signed(rd_data.due) < $signed(now_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      ins_idx_in   = ins_idx_ff;
      fired_in     = fired_ff;
      new_due_in   = new_due_ff;
      new_tag_in   = new_tag_ff;
      now_in       = now_ff;
      is_exec_in   = is_exec_ff;
      rejected_in  = rejected_ff;
      load_rsp     = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_count_in = rsp_count_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      wr_data      = new_entry;

      unique case (state_ff)
         teq_pkg::ST_IDLE: begin
            if (req_fire) begin
               new_due_in  = req_due_time;
               new_tag_in  = teq_pkg::TAG_W'(req_event_tag);
               now_in      = req_current_time;
               is_exec_in  = req_is_exec;
               rejected_in = 1'b0;
               fired_in    = '0;
               if (req_is_exec) begin
                  // The head entry is read this cycle and judged in the next.
                  state_in = (occ_ff == '0) ? teq_pkg::ST_DONE : teq_pkg::ST_EXE;
               end else if (occ_ff == teq_pkg::DEPTH_OCC) begin
                  rejected_in = 1'b1;
                  state_in    = teq_pkg::ST_DONE;
               end else if (occ_ff == '0) begin
                  wr_en           = 1'b1;
                  wr_addr         = head_ff;
                  wr_data.due     = req_due_time;
                  wr_data.tag     = teq_pkg::TAG_W'(req_event_tag);
                  occ_in          = occ_ff + 1'b1;
                  state_in        = teq_pkg::ST_DONE;
               end else begin
                  // Walk from the tail toward the head.
                  ins_idx_in = teq_pkg::IDX_W'(occ_ff - 1'b1);
                  state_in   = teq_pkg::ST_INS;
               end
            end
         end

         teq_pkg::ST_INS: begin
            wr_en = 1'b1;
            if (rd_is_late) begin
               // Move the stored entry one slot back and look at the one before it.
               wr_addr = teq_pkg::slot_addr(head_ff, ins_idx_ff + 1'b1);
               wr_data = rd_data;
               if (ins_idx_ff == '0) begin
                  state_in = teq_pkg::ST_PUT;
               end else begin
                  ins_idx_in = ins_idx_ff - 1'b1;
               end
            end else begin
               wr_addr  = teq_pkg::slot_addr(head_ff, ins_idx_ff + 1'b1);
               occ_in   = occ_ff + 1'b1;
               state_in = teq_pkg::ST_DONE;
            end
         end

         teq_pkg::ST_PUT: begin
            // Every stored entry moved back; the new event becomes the head.
            wr_en    = 1'b1;
            wr_addr  = head_ff;
            occ_in   = occ_ff + 1'b1;
            state_in = teq_pkg::ST_DONE;
         end

         teq_pkg::ST_EXE: begin
            if (!rd_is_due) begin
               state_in = teq_pkg::ST_DONE;
            end else if (out_free) begin
               load_rsp     = 1'b1;
               rsp_kind_in  = teq_pkg::KIND_FIRE;
               rsp_tag_in   = teq_pkg::TAG_FIELD_W'(rd_data.tag);
               rsp_time_in  = rd_data.due;
               rsp_count_in = '0;
               rsp_rej_in   = 1'b0;
               rsp_last_in  = 1'b0;
               head_in      = teq_pkg::slot_addr(head_ff, teq_pkg::IDX_W'(1));
               occ_in       = occ_ff - 1'b1;
               fired_in     = fired_ff + 1'b1;
               if (occ_ff == teq_pkg::OCC_W'(1)) begin
                  state_in = teq_pkg::ST_DONE;
               end
            end
         end

         teq_pkg::ST_DONE: begin
            if (out_free) begin
               load_rsp     = 1'b1;
               rsp_kind_in  = is_exec_ff ? teq_pkg::KIND_DONE : teq_pkg::KIND_ACK;
               rsp_tag_in   = '0;
               rsp_time_in  = '0;
               rsp_count_in = is_exec_ff ? fired_ff : '0;
               rsp_rej_in   = is_exec_ff ? 1'b0 : rejected_ff;
               rsp_last_in  = 1'b1;
               state_in     = teq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = teq_pkg::ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Read address: during the insertion walk it is the next entry toward the head; otherwise
   // it follows the next head, so the entry is ready the cycle after a head advances.
   always_comb begin
      if (state_ff == teq_pkg::ST_INS || (state_ff == teq_pkg::ST_IDLE && !req_is_exec)) begin
         rd_addr = teq_pkg::slot_addr(head_ff, ins_idx_in);
      end else begin
         rd_addr = head_in;
      end
   end

   teq_entry_ram #(
      .WIDTH ($bits(teq_pkg::entry_type)),
      .DEPTH (teq_pkg::DEPTH),
      .ADDR_W(teq_pkg::IDX_W)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= teq_pkg::ST_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_idx_ff   <= ins_idx_in;
      fired_ff     <= fired_in;
      new_due_ff   <= new_due_in;
      new_tag_ff   <= new_tag_in;
      now_ff       <= now_in;
      is_exec_ff   <= is_exec_in;
      rejected_ff  <= rejected_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_count_ff <= rsp_count_in;
      rsp_rej_ff   <= rsp_rej_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_rej_ff, rsp_count_ff, rsp_time_ff, rsp_tag_ff};

   // The queue never holds more events than it has slots.
   assert property (@(posedge clock) disable iff (reset) occ_ff <= teq_pkg::DEPTH_OCC)
      else $error("queue occupancy above its depth");

   // Fired events are never the last result; acknowledges and finish items always are.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != teq_pkg::KIND_FIRE)))
      else $error("last mark does not match result kind");

   // A rejected acknowledge is only possible as an add acknowledge.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[53]) |-> (rsp_tuser == teq_pkg::KIND_ACK))
      else $error("reject flag on a result that is not an add acknowledge");

   // An accepted request is followed by work in flight, never by a second acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted while the previous one is still in flight");

endmodule

// ===== hw/rtl/teq_entry_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module teq_entry_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the timed event queue: directed and random requests vs. a predictor.

// Tracks the pending events the way the queue should hold them and lists the responses each
// accepted request must produce, then checks the responses as they arrive.
class due_event_tracker;

   typedef struct {
      int                            due;
      logic [teq_pkg::TAG_W-1:0]     tag;
   } pending_event_type;

   typedef struct {
      teq_pkg::kind_type kind;
      logic [15:0]       tag;
      logic [31:0]       fire_time;
      logic [4:0]        count;
      logic              rejected;
      logic              last;
   } response_type;

   pending_event_type pending[$];
   response_type      awaited[$];
   int                errors;

   function new();
      errors = 0;
   endfunction

   // Appends one response to the end of the outstanding list.
   function void queue_response(response_type r);
      awaited.insert(awaited.size(), r);
   endfunction

   // Works out the responses of one accepted request and updates the pending events.
   function void note_request(teq_pkg::cmd_type cmd, int due, int now, logic [15:0] tag);
      int                pos;
      int                fired;
      response_type      r;
      pending_event_type e;
      r.kind      = teq_pkg::KIND_ACK;
      r.tag       = '0;
      r.fire_time = '0;
      r.count     = '0;
      r.rejected  = 1'b0;
      r.last      = 1'b1;
      if (cmd == teq_pkg::CMD_ADD) begin
         if (pending.size() >= teq_pkg::DEPTH) begin
            r.rejected = 1'b1;
         end else begin
            // New event goes ahead of every stored event with the same due time.
            pos = 0;
            while (pos < pending.size() && pending[pos].due < due) begin
               pos++;
            end
            e.due = due;
            e.tag = tag[teq_pkg::TAG_W-1:0];
            pending.insert(pos, e);
         end
         queue_response(r);
      end else begin
         fired = 0;
         // Only events strictly earlier than the current time fire.
         while (pending.size() > 0 && pending[0].due < now) begin
            r.kind      = teq_pkg::KIND_FIRE;
            r.tag       = 16'(pending[0].tag);
            r.fire_time = pending[0].due;
            r.last      = 1'b0;
            queue_response(r);
            void'(pending.pop_front());
            fired++;
         end
         r.kind      = teq_pkg::KIND_DONE;
         r.tag       = '0;
         r.fire_time = '0;
         r.count     = 5'(fired);
         r.last      = 1'b1;
         queue_response(r);
      end
   endfunction

   function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   // Compares one accepted response with the oldest outstanding one.
   function void check_response(logic [1:0] kind, logic [15:0] tag, logic [31:0] fire_time,
                                logic [4:0] count, logic rejected, logic last, logic [1:0] pad);
      response_type r;
      if (awaited.size() == 0) begin
         $error("response with none outstanding: kind %0h tag %0h time %0h", kind, tag,
                fire_time);
         errors++;
      end else begin
         r = awaited.pop_front();
         match_field("kind", 32'(r.kind), 32'(kind));
         match_field("fired_tag", 32'(r.tag), 32'(tag));
         match_field("fired_time", r.fire_time, fire_time);
         match_field("fired_count", 32'(r.count), 32'(count));
         match_field("rejected", 32'(r.rejected), 32'(rejected));
         match_field("last", 32'(r.last), 32'(last));
         match_field("pad", 32'd0, 32'(pad));
      end
   endfunction

endclass

module tb;

   // Cycles without any handshake on either channel before the run is declared hung.
   // The slowest legal request is an add that shifts a whole queue, and the random stalls on
   // both sides are short, so this is far beyond any correct run.
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 290;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_TIME     = 32'sh7fff_ffff;
   localparam int MIN_TIME     = 32'sh8000_0000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;  // [31:0] due_time, [63:32] current_time, [79:64] event_tag
   logic [0:0]  req_tuser  = '0;  // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // [15:0] fired_tag, [47:16] fired_time,
                                  // [52:48] fired_count, [53] rejected, [55:54] zero
   logic [1:0]  rsp_tuser;        // [1:0] kind
   logic        rsp_tlast;

   due_event_tracker sb = new();

   // When calm is set neither side idles, so back-to-back requests and responses get covered.
   bit          calm = 1'b0;
   int          sent = 0;
   int unsigned stall_cycles = 0;

   timed_event_queue_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Presents one request, with an occasional idle gap in front of it, and holds it until the
   // block takes it. The tracker is told at the very edge where the handshake happens. When no
   // gap is taken, valid simply stays high into the next request, so it is assigned once a step.
   task automatic send_request(teq_pkg::cmd_type cmd, int due, int now, logic [15:0] tag);
      while (!calm && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {tag, now, due};
      req_tuser  <= cmd;
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.note_request(cmd, due, now, tag);
      sent++;
   endtask

   // The unused fields carry random values, since the block must ignore them.
   task automatic add_event(int due, logic [15:0] tag);
      send_request(teq_pkg::CMD_ADD, due, int'($urandom), tag);
   endtask

   task automatic execute_due(int now);
      send_request(teq_pkg::CMD_EXEC, int'($urandom), now, 16'($urandom));
   endtask

   // Response side: check every accepted response, then decide whether to stall next cycle.
   // Both the handshake signals and the outputs are read before this edge's updates land.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tuser, rsp_tdata[15:0], rsp_tdata[47:16], rsp_tdata[52:48],
                           rsp_tdata[53], rsp_tlast, rsp_tdata[55:54]);
      end
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
   end

   // Watchdog: a hang shows up as a long run of cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      int base;
      int burst;
      int pick;
      int first_random;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Executing an empty queue yields only the finished response with a zero count.
      execute_due(0);

      // The most negative time, plus two events sharing a time that must leave newest first.
      add_event(MIN_TIME, 16'hffff);
      add_event(5, 16'h0001);
      add_event(5, 16'h0002);
      add_event(-1, 16'h0003);
      // Events due exactly at the current time are not yet due and stay queued.
      execute_due(5);
      execute_due(6);

      // Fill the queue with descending times so every insert lands at the head and shifts
      // the whole queue, then one more add that must be rejected.
      for (int i = 0; i < teq_pkg::DEPTH; i++) begin
         add_event(100 - i, 16'($urandom));
      end
      add_event(int'($urandom), 16'($urandom));
      // Sixteen events firing in one go, which needs the top bit of the count.
      execute_due(MAX_TIME);

      // Random part. Most of it is bursts of adds clustered around a base time, so equal
      // times are frequent, followed by an execute that fires part of what is queued. Bursts
      // often overflow the queue. Drains and fully random requests make up the rest.
      first_random = sent;
      while (sent < first_random + RANDOM_ITEMS) begin
         calm = (sent >= first_random + 120) && (sent < first_random + 200);
         pick = $urandom_range(99);
         if (pick < 70) begin
            base  = ($urandom_range(3) == 0) ? int'($urandom) : int'($urandom_range(2000)) - 1000;
            burst = $urandom_range(1, 18);
            repeat (burst) begin
               add_event(base + int'($urandom_range(7)), 16'($urandom));
            end
            execute_due(base + int'($urandom_range(9)));
         end else if (pick < 85) begin
            execute_due(($urandom_range(1) == 1) ? MAX_TIME : int'($urandom));
         end else begin
            send_request(teq_pkg::cmd_type'($urandom_range(1)), int'($urandom),
                         int'($urandom), 16'($urandom));
         end
      end
      calm = 1'b0;

      // The largest time can never fire, so it comes last: it would sit in the queue for good.
      add_event(MAX_TIME, 16'h5a5a);
      execute_due(MAX_TIME);
      req_tvalid <= 1'b0;

      // Wait for every outstanding response, then a little longer to catch stray extras.
      while (sb.awaited.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
